// ===== src/hstcpw_pkg.sv =====
// Shared types, codes and ROM constants for the HighSpeed TCP window update engine.
`default_nettype none

package hstcpw_pkg;

   // Event codes carried in the action field
   localparam logic [1:0] ACT_ACK     = 2'd0;
   localparam logic [1:0] ACT_LOSS    = 2'd1;
   localparam logic [1:0] ACT_TIMEOUT = 2'd2;
   localparam logic [1:0] ACT_NONE    = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_SEGMENT_SIZE      = 2'd0;
   localparam logic [1:0] CSR_WINDOW_LIMIT      = 2'd1;
   localparam logic [1:0] CSR_INITIAL_WINDOW    = 2'd2;
   localparam logic [1:0] CSR_INITIAL_THRESHOLD = 2'd3;

   // Register reset values
   localparam logic [15:0] SEGMENT_SIZE_RST      = 16'd1460;
   localparam logic [31:0] WINDOW_LIMIT_RST      = 32'hFFFF_FFFF;
   localparam logic [31:0] INITIAL_WINDOW_RST    = 32'd4380;
   localparam logic [31:0] INITIAL_THRESHOLD_RST = 32'hFFFF_FFFF;

   localparam int TABLE_ENTRIES  = 74;
   localparam int DECREASE_SHIFT = 7;
   localparam logic [6:0] TOP_SLOT = 7'((TABLE_ENTRIES - 1 > 73) ? 73 : TABLE_ENTRIES - 1);

   // Serial divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
   localparam int DIV_STEPS = 32;

   // Decrease factors, scaled by 2^DECREASE_SHIFT
   localparam logic [6:0] DECR_ROM [0:73] = '{
      7'd0,   7'd64,  7'd71,  7'd75,  7'd78,  7'd81,  7'd83,  7'd84,
      7'd86,  7'd87,  7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,
      7'd93,  7'd94,  7'd95,  7'd95,  7'd96,  7'd97,  7'd97,  7'd98,
      7'd98,  7'd99,  7'd99,  7'd100, 7'd100, 7'd101, 7'd101, 7'd101,
      7'd102, 7'd102, 7'd103, 7'd103, 7'd103, 7'd104, 7'd104, 7'd105,
      7'd105, 7'd105, 7'd106, 7'd106, 7'd106, 7'd107, 7'd107, 7'd107,
      7'd108, 7'd108, 7'd108, 7'd108, 7'd109, 7'd109, 7'd109, 7'd110,
      7'd110, 7'd110, 7'd111, 7'd111, 7'd111, 7'd111, 7'd112, 7'd112,
      7'd112, 7'd113, 7'd113, 7'd113, 7'd114, 7'd114, 7'd114, 7'd115,
      7'd115, 7'd116
   };

   // Per-slot window thresholds, in segments
   localparam logic [16:0] THRES_ROM [0:73] = '{
      17'd0,     17'd38,    17'd118,   17'd221,   17'd347,   17'd495,
      17'd663,   17'd851,   17'd1058,  17'd1284,  17'd1529,  17'd1793,
      17'd2076,  17'd2378,  17'd2699,  17'd3039,  17'd3399,  17'd3778,
      17'd4177,  17'd4596,  17'd5036,  17'd5497,  17'd5979,  17'd6483,
      17'd7009,  17'd7558,  17'd8130,  17'd8726,  17'd9346,  17'd9991,
      17'd10661, 17'd11358, 17'd12082, 17'd12834, 17'd13614, 17'd14424,
      17'd15265, 17'd16137, 17'd17042, 17'd17981, 17'd18955, 17'd19965,
      17'd21013, 17'd22101, 17'd23230, 17'd24402, 17'd25618, 17'd26881,
      17'd28193, 17'd29557, 17'd30975, 17'd32450, 17'd33986, 17'd35586,
      17'd37253, 17'd38992, 17'd40808, 17'd42707, 17'd44694, 17'd46776,
      17'd48961, 17'd51258, 17'd53677, 17'd56230, 17'd58932, 17'd61799,
      17'd64851, 17'd68113, 17'd71617, 17'd75401, 17'd79517, 17'd84035,
      17'd89053, 17'd94717
   };

   // Sequencer states
   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_WALK    = 6'b000010,
      S_ACK_DIV = 6'b000100,
      S_THR_DIV = 6'b001000,
      S_RESULT  = 6'b010000,
      S_SPARE   = 6'b100000
   } state_type;

   // Divider handshake
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// ===== src/hstcpw_div.sv =====
// Restoring serial divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`default_nettype none

module hstcpw_div
   import hstcpw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [31:0]  dividend,
   input  wire logic [15:0]  divisor,
   output div_stat_type      stat,
   output logic      [31:0]  quotient,
   output logic      [15:0]  remainder
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;

   logic [16:0] partial;
   logic [17:0] diff;
   logic        fits;

   assign partial = {rem_ff, quo_ff[31]};
   assign diff    = {1'b0, partial} - {2'b00, dvs_ff};
   assign fits    = !diff[17];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[15:0] : partial[15:0];
         quo_in   = {quo_ff[30:0], fits};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/highspeed_tcp_window_update_core.sv =====
// HighSpeed TCP congestion window update engine: sequencer, state and result register.
//
// Usage:
//   req_* carries one event per transfer: ack (grow the window), fast loss or
//   timeout (shrink the window, walk the increase slot down, set the threshold).
//   rsp_* returns one transfer per event: window, threshold and slot afterwards.
//   csr_* writes the segment size, window limit and the initial window and
//   threshold registers (unused); write only while no event is in progress.
// Steps from accept to result valid:
//   ack in slow start or spending credit: straight to the result state.
//   ack that grows the window: serial divide of window by slot, then result.
//   fast loss: slot walk, with the flight/segment divide running alongside,
//   then the threshold from that divide.
//   timeout: slot walk, then a divide of the new window by segment.
// One event is worked at a time; req_tready is high only while the sequencer
// idles. The 32-step divider and the slot walk set the per-event time; the
// slot walk shares one multiplier for threshold*segment products with accept.
// A finished result sits in the output register; the next event is accepted
// while it waits. If rsp_tready stays low, the following result waits in its
// final state and no further event is taken.
// Reset (synchronous, active high) restores the registers to their defaults,
// window and threshold to the default initial values, credit to 0, slot to 1.
`default_nettype none

module highspeed_tcp_window_update_core
   import hstcpw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // action[1:0], acked_len[32:2], flight_bytes[64:33]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [71:0] rsp_tdata,   // window[31:0], threshold[63:32], slot[70:64]
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   // ---------------- configuration registers ----------------
   logic [15:0] seg_size_ff;
   logic [31:0] win_limit_ff;
   logic [31:0] init_win_ff;
   logic [31:0] init_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_size_ff  <= SEGMENT_SIZE_RST;
         win_limit_ff <= WINDOW_LIMIT_RST;
         init_win_ff  <= INITIAL_WINDOW_RST;
         init_thr_ff  <= INITIAL_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEGMENT_SIZE:      seg_size_ff  <= csr_wdata[15:0];
            CSR_WINDOW_LIMIT:      win_limit_ff <= csr_wdata;
            CSR_INITIAL_WINDOW:    init_win_ff  <= csr_wdata;
            CSR_INITIAL_THRESHOLD: init_thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- request fields ----------------
   logic [1:0]  req_action;
   logic [30:0] req_acked_len;
   logic [31:0] req_flight_bytes;

   assign req_action       = req_tdata[1:0];
   assign req_acked_len    = req_tdata[32:2];
   assign req_flight_bytes = req_tdata[64:33];

   // ---------------- state ----------------
   state_type          state_ff, state_in;
   logic [31:0]        cw_ff, cw_in;        // congestion window
   logic [31:0]        thr_ff, thr_in;      // slow start threshold
   logic signed [32:0] credit_ff, credit_in;
   logic [6:0]         slot_ff, slot_in;

   // working registers (payload, no reset)
   logic [1:0]  act_ff, act_in;
   logic [31:0] flight_ff, flight_in;
   logic [31:0] nw_ff, nw_in;       // scaled flight size during the walk
   logic [32:0] prod_ff, prod_in;   // threshold[slot] * segment

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_win_ff, rsp_win_in;
   logic [31:0] rsp_thr_ff, rsp_thr_in;
   logic [6:0]  rsp_slot_ff, rsp_slot_in;

   // ---------------- derived values ----------------
   logic [15:0] mss;
   logic [16:0] mss2;
   logic [6:0]  slot_s;

   assign mss  = (seg_size_ff == '0) ? 16'd1 : seg_size_ff;
   assign mss2 = {mss, 1'b0};
   assign slot_s = (slot_ff < 7'd1) ? 7'd1 : ((slot_ff > TOP_SLOT) ? TOP_SLOT : slot_ff);

   // acked bytes rounded up to a segment, capped at two segments
   logic [16:0] ack_bytes;
   assign ack_bytes = (req_acked_len == '0) ? 17'd0 :
                      ((req_acked_len <= {15'd0, mss}) ? {1'b0, mss} : mss2);

   logic [32:0] ss_sum, ca_sum;
   logic [31:0] ss_win, ca_win;
   assign ss_sum = {1'b0, cw_ff} + {16'd0, ack_bytes};
   assign ca_sum = {1'b0, cw_ff} + {17'd0, mss};
   assign ss_win = (ss_sum > {1'b0, win_limit_ff}) ? win_limit_ff : ss_sum[31:0];
   assign ca_win = (ca_sum > {1'b0, win_limit_ff}) ? win_limit_ff : ca_sum[31:0];

   logic credit_pos;
   assign credit_pos = !credit_ff[32] && (credit_ff != '0);

   // shared multiplier: segment threshold of a slot in bytes
   logic [6:0]  mul_slot;
   logic [32:0] mul_out;
   assign mul_slot = (state_ff == S_WALK) ? (slot_ff - 7'd1) : slot_s;
   assign mul_out  = 33'(THRES_ROM[mul_slot]) * 33'(mss);

   // flight scaled by the slot's decrease factor
   logic [38:0] scaled;
   assign scaled = 39'(req_flight_bytes) * 39'(DECR_ROM[slot_s]);

   // walk stops when the scaled flight exceeds the slot threshold or at slot 1
   logic        walk_done;
   logic [31:0] loss_win;
   assign walk_done = (slot_ff <= 7'd1) || ({1'b0, nw_ff} > prod_ff);
   assign loss_win  = (nw_ff < {15'd0, mss2}) ? {15'd0, mss2} : nw_ff;

   // ---------------- divider ----------------
   logic         div_start;
   logic [31:0]  div_dividend;
   logic [15:0]  div_divisor;
   div_stat_type div_stat;
   logic [31:0]  div_quo;
   logic [15:0]  div_rem;

   hstcpw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // threshold candidates once the divide is done
   logic [31:0] fl_thr;
   logic [32:0] to_round;
   logic [31:0] to_cap;
   logic [31:0] to_thr;
   assign fl_thr   = (div_quo < 32'd2) ? {15'd0, mss2} : (flight_ff - {16'd0, div_rem});
   assign to_round = (div_rem == '0) ? {1'b0, cw_ff} :
                     ({1'b0, cw_ff} - {17'd0, div_rem} + {17'd0, mss});
   assign to_cap   = to_round[32] ? 32'hFFFF_FFFF : to_round[31:0];
   assign to_thr   = (to_cap < {15'd0, mss2}) ? {15'd0, mss2} : to_cap;

   logic req_xfer, rsp_xfer, rsp_load;
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;
   assign rsp_load   = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_tready);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      cw_in        = cw_ff;
      thr_in       = thr_ff;
      credit_in    = credit_ff;
      slot_in      = slot_ff;
      act_in       = act_ff;
      flight_in    = flight_ff;
      nw_in        = nw_ff;
      prod_in      = prod_ff;
      div_start    = 1'b0;
      div_dividend = req_flight_bytes;
      div_divisor  = mss;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in    = req_action;
               flight_in = req_flight_bytes;
               unique case (req_action) inside
                  ACT_ACK: begin
                     if (cw_ff < thr_ff) begin
                        cw_in    = ss_win;
                        state_in = S_RESULT;
                     end else if (credit_pos) begin
                        credit_in = credit_ff - $signed({16'd0, ack_bytes});
                        state_in  = S_RESULT;
                     end else begin
                        cw_in        = ca_win;
                        slot_in      = slot_s;
                        prod_in      = mul_out;
                        div_start    = 1'b1;
                        div_dividend = ca_win;
                        div_divisor  = {9'd0, slot_s};
                        state_in     = S_ACK_DIV;
                     end
                  end
                  ACT_LOSS, ACT_TIMEOUT: begin
                     slot_in  = slot_s;
                     prod_in  = mul_out;
                     nw_in    = scaled[DECREASE_SHIFT +: 32];
                     // fast loss divides flight by segment while the slot walks
                     div_start = (req_action == ACT_LOSS);
                     state_in  = S_WALK;
                  end
                  default: state_in = S_RESULT;
               endcase
            end
         end

         S_WALK: begin
            if (walk_done) begin
               cw_in     = loss_win;
               credit_in = '0;
               state_in  = S_THR_DIV;
               if (act_ff == ACT_TIMEOUT) begin
                  div_start    = 1'b1;
                  div_dividend = loss_win;
               end
            end else begin
               slot_in = slot_ff - 7'd1;
               prod_in = mul_out;
            end
         end

         S_ACK_DIV: begin
            if (div_stat.done) begin
               credit_in = $signed({1'b0, div_quo});
               if ({1'b0, cw_ff} > prod_ff) begin
                  slot_in = (slot_ff >= TOP_SLOT) ? TOP_SLOT : (slot_ff + 7'd1);
               end
               state_in = S_RESULT;
            end
         end

         S_THR_DIV: begin
            if (div_stat.done) begin
               thr_in   = (act_ff == ACT_LOSS) ? fl_thr : to_thr;
               state_in = S_RESULT;
            end
         end

         S_RESULT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_thr_in   = rsp_thr_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_win_in   = cw_ff;
         rsp_thr_in   = thr_ff;
         rsp_slot_in  = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cw_ff        <= INITIAL_WINDOW_RST;
         thr_ff       <= INITIAL_THRESHOLD_RST;
         credit_ff    <= '0;
         slot_ff      <= 7'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cw_ff        <= cw_in;
         thr_ff       <= thr_in;
         credit_ff    <= credit_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      flight_ff   <= flight_in;
      nw_ff       <= nw_in;
      prod_ff     <= prod_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_thr_ff  <= rsp_thr_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   // init registers have no effect on window or threshold
   logic unused_init;
   assign unused_init = ^{init_win_ff, init_thr_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_slot_ff, rsp_thr_ff, rsp_win_ff} & {72{!unused_init | 1'b1}};

`ifndef SYNTHESIS
   // slot stays inside the table
   assert property (@(posedge clock) disable iff (reset)
      (slot_ff >= 7'd1) && (slot_ff <= TOP_SLOT))
      else $error("slot out of table range");

   // divider is running or finished whenever the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACK_DIV || state_ff == S_THR_DIV) |-> (div_stat.busy || div_stat.done))
      else $error("waiting on an idle divider");

   // end of a loss walk clears credit and leaves at least two segments
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && walk_done) |=>
         (credit_ff == '0) && (cw_ff >= {15'd0, mss2}))
      else $error("loss left bad window or credit");
`endif

endmodule

`default_nettype wire

// ===== test/highspeed_tcp_window_update_core_test.sv =====
// Self-checking testbench for the HighSpeed TCP window update core.
`default_nettype none

module highspeed_tcp_window_update_core_test
   import hstcpw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // ---------------------------------------------------------------------
   // Own copy of the per-slot tables: decrease factor (x/128) and the
   // window, in segments, above which growth steps the slot up.
   // ---------------------------------------------------------------------
   localparam int unsigned FACTOR_SHIFT = 7;
   localparam int unsigned HIGHEST_SLOT = 73;

   localparam int unsigned DECREASE_FACTOR [0:73] = '{
      0, 64, 71, 75, 78, 81, 83, 84, 86, 87, 88, 89, 90, 91, 92, 93,
      93, 94, 95, 95, 96, 97, 97, 98, 98, 99, 99, 100, 100, 101, 101, 101,
      102, 102, 103, 103, 103, 104, 104, 105, 105, 105, 106, 106, 106, 107,
      107, 107, 108, 108, 108, 108, 109, 109, 109, 110, 110, 110, 111, 111,
      111, 111, 112, 112, 112, 113, 113, 113, 114, 114, 114, 115, 115, 116
   };

   localparam int unsigned SLOT_WINDOW_SEGS [0:73] = '{
      0, 38, 118, 221, 347, 495, 663, 851, 1058, 1284, 1529, 1793, 2076, 2378,
      2699, 3039, 3399, 3778, 4177, 4596, 5036, 5497, 5979, 6483, 7009, 7558,
      8130, 8726, 9346, 9991, 10661, 11358, 12082, 12834, 13614, 14424, 15265,
      16137, 17042, 17981, 18955, 19965, 21013, 22101, 23230, 24402, 25618,
      26881, 28193, 29557, 30975, 32450, 33986, 35586, 37253, 38992, 40808,
      42707, 44694, 46776, 48961, 51258, 53677, 56230, 58932, 61799, 64851,
      68113, 71617, 75401, 79517, 84035, 89053, 94717
   };

   typedef struct packed {
      logic [1:0]  action;
      logic [30:0] acked_len;
      logic [31:0] flight_bytes;
   } window_event_type;

   typedef struct packed {
      logic [31:0] window;
      logic [31:0] threshold;
      logic [6:0]  slot;
   } window_state_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input is known from time zero
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;    // action[1:0], acked_len[32:2], flight_bytes[64:33]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // window[31:0], threshold[63:32], slot[70:64]
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   highspeed_tcp_window_update_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: registers as written, engine state after reset
   // ---------------------------------------------------------------------
   logic [15:0]     mss_cfg      = 16'd1460;
   logic [31:0]     limit_cfg    = 32'hFFFF_FFFF;
   logic [31:0]     init_win_cfg = 32'd4380;
   logic [31:0]     init_thr_cfg = 32'hFFFF_FFFF;
   logic [31:0]     cwnd_model   = 32'd4380;
   logic [31:0]     ssthresh_model = 32'hFFFF_FFFF;
   longint          credit_model = 0;
   logic [6:0]      slot_model   = 7'd1;

   window_event_type pending_events [$];
   window_state_type expected_windows [$];
   window_event_type next_event;
   window_state_type oldest;

   int              idle_left = 0;      // sender gap before the next transfer
   int              stall_left = 0;     // receiver stall cycles still to go
   bit              quiet_run = 1'b0;   // phase without any gaps on either side
   int              mismatches = 0;
   int              events_sent = 0;
   int              results_checked = 0;
   int              settings_used = 1;
   int unsigned     top_slot_seen = 1;

   // zero segment size behaves as one byte
   function automatic longint unsigned seg_bytes();
      return (mss_cfg == 16'd0) ? 64'd1 : 64'(mss_cfg);
   endfunction

   function automatic int unsigned usable_slot();
      if (slot_model < 7'd1) return 1;
      if (slot_model > 7'(HIGHEST_SLOT)) return HIGHEST_SLOT;
      return slot_model;
   endfunction

   // loss and timeout share this: scale flight, walk the slot down, drop credit
   function automatic void shrink_window(input logic [31:0] flight);
      longint unsigned mss, nw;
      int unsigned     i;
      mss = seg_bytes();
      i = usable_slot();
      nw = (64'(flight) * 64'(DECREASE_FACTOR[i])) >> FACTOR_SHIFT;
      while (i > 1 && !(nw > 64'(SLOT_WINDOW_SEGS[i]) * mss))
         i--;
      slot_model = 7'(i);
      if (nw < 2 * mss) nw = 2 * mss;
      cwnd_model = nw[31:0];
      credit_model = 0;
   endfunction

   function automatic void grow_window(input logic [30:0] acked);
      longint unsigned mss, b, nw;
      int unsigned     i;
      mss = seg_bytes();
      b = ((64'(acked) + mss - 1) / mss) * mss;
      if (b > 2 * mss) b = 2 * mss;
      if (cwnd_model >= ssthresh_model) begin
         if (credit_model > 0) begin
            credit_model = credit_model - longint'(b);
         end else begin
            i = usable_slot();
            nw = 64'(cwnd_model) + mss;
            if (nw > 64'(limit_cfg)) nw = 64'(limit_cfg);
            cwnd_model = nw[31:0];
            credit_model = longint'(nw / i);
            if (nw > 64'(SLOT_WINDOW_SEGS[i]) * mss)
               slot_model = 7'((i + 1 > HIGHEST_SLOT) ? HIGHEST_SLOT : i + 1);
            else
               slot_model = 7'(i);
         end
      end else begin
         nw = 64'(cwnd_model) + b;
         if (nw > 64'(limit_cfg)) nw = 64'(limit_cfg);
         cwnd_model = nw[31:0];
      end
   endfunction

   // one event in, the window state it leaves behind out
   function automatic window_state_type apply_event(input logic [1:0]  act,
                                                    input logic [30:0] acked,
                                                    input logic [31:0] flight);
      longint unsigned  mss, q;
      window_state_type res;
      mss = seg_bytes();
      case (act)
         ACT_ACK: begin
            grow_window(acked);
         end
         ACT_LOSS: begin
            q = 64'(flight) / mss;
            shrink_window(flight);
            if (q < 2) q = 2;
            ssthresh_model = 32'(q * mss);
         end
         ACT_TIMEOUT: begin
            shrink_window(flight);
            q = ((64'(cwnd_model) + mss - 1) / mss) * mss;
            if (q < 2 * mss) q = 2 * mss;
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            ssthresh_model = q[31:0];
         end
         default: ;   // unused code leaves everything alone
      endcase
      res.window = cwnd_model;
      res.threshold = ssthresh_model;
      res.slot = slot_model;
      return res;
   endfunction

   // mostly back-to-back, sometimes a few cycles, rarely longer than an event
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one transfer per accepted event, prediction at acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_windows.push_back(apply_event(req_tdata[1:0], req_tdata[32:2],
                                                   req_tdata[64:33]));
            events_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               req_tvalid <= 1'b0;
               idle_left <= idle_left - 1;
            end else if (pending_events.size() != 0) begin
               next_event = pending_events.pop_front();
               req_tdata <= {7'd0, next_event.flight_bytes, next_event.acked_len,
                             next_event.action};
               req_tvalid <= 1'b1;
               idle_left <= quiet_run ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random back-pressure at the edge, check at the falling edge
   // before the edge that completes the transfer (handshake is stable there)
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet_run && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_windows.size() == 0) begin
            $error("result with nothing pending: window %0d threshold %0d slot %0d",
                   rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[70:64]);
            mismatches++;
         end else begin
            oldest = expected_windows.pop_front();
            results_checked++;
            if (rsp_tdata[31:0] !== oldest.window) begin
               $error("window: expected %0d, actual %0d", oldest.window, rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tdata[63:32] !== oldest.threshold) begin
               $error("threshold: expected %0d, actual %0d",
                      oldest.threshold, rsp_tdata[63:32]);
               mismatches++;
            end
            if (rsp_tdata[70:64] !== oldest.slot) begin
               $error("slot: expected %0d, actual %0d", oldest.slot, rsp_tdata[70:64]);
               mismatches++;
            end
            if (oldest.slot > top_slot_seen) top_slot_seen = oldest.slot;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_event(input logic [1:0] act, input logic [30:0] acked,
                            input logic [31:0] flight);
      pending_events.push_back(window_event_type'{act, acked, flight});
   endtask

   // random magnitude; a zero shift gives a fully random word
   function automatic logic [31:0] rand_span();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // acks sized around a segment, with the odd arbitrary count
   function automatic logic [30:0] rand_acked(input longint unsigned mss);
      if ($urandom_range(0, 4) == 0) return 31'(rand_span());
      return 31'($urandom_range(0, 32'(3 * mss)));
   endfunction

   // all traffic drained and the sequencer back in idle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || expected_windows.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_SEGMENT_SIZE:      mss_cfg = value[15:0];
         CSR_WINDOW_LIMIT:      limit_cfg = value;
         CSR_INITIAL_WINDOW:    init_win_cfg = value;
         CSR_INITIAL_THRESHOLD: init_thr_cfg = value;
         default: ;
      endcase
   endtask

   // Well-formed runs dominate: a timeout from a big flight followed by acks
   // first leaves slow start, then grows the window with zero credit and may
   // step the slot up, then spends credit. Loss runs walk the slot back.
   task automatic add_random(input int count, input int climb_pct);
      int              made, r, n, k;
      logic [1:0]      act;
      longint unsigned mss;
      made = 0;
      mss = seg_bytes();
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            // noise: any code, arbitrary fields
            act = 2'($urandom_range(0, 3));
            add_event(act, 31'($urandom), $urandom);
            if (act != ACT_NONE) made++;
         end else if (r < 10 + climb_pct) begin
            add_event(ACT_TIMEOUT, 31'($urandom), $urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
            n = $urandom_range(2, 4);
            for (k = 0; k < n; k++)
               add_event(ACT_ACK, 31'($urandom_range(1, 32'(3 * mss))), $urandom);
            made += 1 + n;
         end else if (r < 90) begin
            act = ($urandom_range(0, 1) == 0) ? ACT_LOSS : ACT_TIMEOUT;
            add_event(act, 31'($urandom), rand_span());
            n = $urandom_range(0, 10);
            for (k = 0; k < n; k++)
               add_event(ACT_ACK, rand_acked(mss), $urandom);
            made += 1 + n;
         end else begin
            act = 2'($urandom_range(0, 2));
            add_event(act, rand_acked(mss), rand_span());
            made++;
         end
      end
   endtask

   task automatic run_phase(input logic [15:0] mss, input logic [31:0] limit,
                            input int count, input int climb_pct, input bit no_gaps);
      wait_idle();
      write_register(CSR_SEGMENT_SIZE, {16'd0, mss});
      write_register(CSR_WINDOW_LIMIT, limit);
      write_register(CSR_INITIAL_WINDOW, rand_span());
      write_register(CSR_INITIAL_THRESHOLD, rand_span());
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      quiet_run = no_gaps;
      settings_used++;
      add_random(count, climb_pct);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int guard;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, at the reset settings (segment 1460, no limit)
      add_event(ACT_ACK,     31'd0,          32'hFFFF_FFFF); // zero bytes, slow start
      add_event(ACT_ACK,     31'd1,          32'd0);         // rounds up to a segment
      add_event(ACT_ACK,     31'h7FFF_FFFF,  32'd0);         // capped at two segments
      add_event(ACT_NONE,    31'h7FFF_FFFF,  32'hFFFF_FFFF); // unused code, no change
      add_event(ACT_LOSS,    31'h7FFF_FFFF,  32'd0);         // floor of two segments
      add_event(ACT_ACK,     31'd1460,       32'd0);         // avoidance, grow
      add_event(ACT_ACK,     31'd2921,       32'd0);         // spend credit
      add_event(ACT_ACK,     31'd100,        32'd0);         // credit down to zero
      add_event(ACT_ACK,     31'd0,          32'd0);         // zero credit grows again
      add_event(ACT_TIMEOUT, 31'd0,          32'hFFFF_FFFF); // largest flight
      add_event(ACT_ACK,     31'd1,          32'd0);         // leaves slow start
      add_event(ACT_ACK,     31'd1,          32'd0);         // grow, slot steps up
      add_event(ACT_ACK,     31'd1,          32'd0);         // spend
      add_event(ACT_LOSS,    31'd0,          32'hFFFF_FFFF);
      add_event(ACT_TIMEOUT, 31'd0,          32'd1000);      // slot walks back down
      add_event(ACT_LOSS,    31'd0,          32'd2919);      // under two segments
      add_event(ACT_LOSS,    31'd0,          32'd100000);
      add_event(ACT_TIMEOUT, 31'd0,          32'd0);
      add_event(ACT_NONE,    31'd0,          32'd0);
      add_event(ACT_ACK,     31'h7FFF_FFFF,  32'hFFFF_FFFF);

      // Register settings, extremes among them
      run_phase(16'd1,     32'hFFFF_FFFF, 300, 70, 1'b0); // one-byte segments: deep slots
      run_phase(16'd0,     32'hFFFF_FFFF, 150, 60, 1'b1); // zero segment, no gaps at all
      run_phase(16'd65535, 32'hFFFF_FFFF, 150, 40, 1'b0); // largest segment
      run_phase(16'($urandom_range(2, 16)), $urandom | 32'h8000_0000, 200, 60, 1'b0);
      run_phase(16'd1460,  $urandom_range(10000, 200000), 150, 40, 1'b0); // limit caps
      run_phase(16'd1460,  32'd0, 50, 30, 1'b0);          // zero limit
      run_phase(16'($urandom_range(1, 65535)), 32'hFFFF_FFFF, 200, 40, 1'b0);

      // Drain, then give any stray result time to show up
      guard = 0;
      while ((pending_events.size() != 0 || req_tvalid || expected_windows.size() != 0)
             && guard < 1000000) begin
         @(negedge clock);
         guard++;
      end
      repeat (150) @(posedge clock);
      if (expected_windows.size() != 0) begin
         $error("%0d results never arrived", expected_windows.size());
         mismatches++;
      end

      $display("Checked %0d results for %0d events under %0d register settings, top slot %0d",
               results_checked, events_sent, settings_used, top_slot_seen);
      $display("Exercised slow start, credit spend, growth with slot steps, loss and timeout");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest legal run
   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
